FILE: design/dic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_pkg
// shared types and constants for the double / int64 converter
// ----------------------------------------------------------------------------
package dic_pkg;

  localparam int unsigned MantBits = 52;
  localparam int unsigned ExpBits  = 11;
  localparam logic [10:0] ExpMax   = 11'h7ff;
  localparam logic [10:0] ExpBias  = 11'd1023;
  localparam logic [63:0] SignBit  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] IntMax   = 64'h7fff_ffff_ffff_ffff;

  typedef enum logic [0:0] {
    CMD_DBL_TO_INT = 1'b0,
    CMD_INT_TO_DBL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [63:0] result;
    logic        range_flag;
  } dic_res_t;

endpackage

FILE: design/dic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_in_if
// input channel: command and operand
// ----------------------------------------------------------------------------
interface dic_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink   (input valid, input cmd, input operand, output ready);
endinterface

FILE: design/dic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_out_if
// output channel: converted value and range flag
// ----------------------------------------------------------------------------
interface dic_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        range_flag;

  modport source (output valid, output result, output range_flag, input ready);
  modport sink   (input valid, input result, input range_flag, output ready);
endinterface

FILE: design/dic_d2i.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_d2i
// double to int64, round half away from zero, saturating
// ----------------------------------------------------------------------------
module dic_d2i (
  input  logic [63:0]      bits,
  output dic_pkg::dic_res_t res
);
  import dic_pkg::*;

  logic        neg;
  logic [10:0] e;
  logic [51:0] m;
  logic [52:0] sig;
  logic [63:0] sig_w;
  logic [10:0] e_eff;
  logic [63:0] mag;
  logic [63:0] shl;
  logic [63:0] shr;
  logic [63:0] rnd;
  logic [5:0]  ls;
  logic [5:0]  rs;

  assign neg   = bits[63];
  assign e     = bits[62:52];
  assign m     = bits[51:0];
  assign e_eff = (e == 11'd0) ? 11'd1 : e;
  assign sig   = {(e != 11'd0), m};
  assign sig_w = {11'd0, sig};
  // e_eff >= 1075 means left shift, e_eff <= 1074 means right shift
  assign ls    = e_eff[5:0] - 6'd51; // e_eff - 1075 mod 64
  assign rs    = 6'd51 - e_eff[5:0]; // 1075 - e_eff mod 64
  assign shl   = sig_w << ls;
  assign shr   = sig_w >> rs;
  assign rnd   = {63'd0, |(sig_w & (64'd1 << (rs - 6'd1)))};

  always_comb begin
    res = '{result: 64'd0, range_flag: 1'b0};
    mag = 64'd0;
    if (e == ExpMax) begin
      res.range_flag = 1'b1;
      res.result = (m != 52'd0) ? 64'd0 : (neg ? SignBit : IntMax);
    end else if (e_eff >= 11'd1086) begin
      if (neg && e_eff == 11'd1086 && m == 52'd0) begin
        res.result = SignBit;
      end else begin
        res.range_flag = 1'b1;
        res.result = neg ? SignBit : IntMax;
      end
    end else begin
      if (e_eff >= 11'd1075) mag = shl;
      else if (e_eff <= 11'd1011) mag = 64'd0;
      else mag = shr + rnd;
      res.result = neg ? (~mag + 64'd1) : mag;
    end
  end
endmodule

FILE: design/dic_i2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dic_i2d
// int64 to double, round to nearest even
// ----------------------------------------------------------------------------
module dic_i2d (
  input  logic [63:0] x,
  output logic [63:0] dbl
);
  import dic_pkg::*;

  logic        neg;
  logic [63:0] mag;
  logic [5:0]  lz;
  logic [63:0] norm;
  logic [52:0] keep;
  logic        guard;
  logic        sticky;
  logic        up;
  logic [53:0] rounded;
  logic [10:0] exp;

  assign neg = x[63];
  assign mag = neg ? (~x + 64'd1) : x;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) lz = 6'(63 - i);
    end
  end

  // leading one moves to bit 63
  assign norm    = mag << lz;
  assign keep    = norm[63:11];
  assign guard   = norm[10];
  assign sticky  = |norm[9:0];
  assign up      = guard && (sticky || keep[0]);
  assign rounded = {1'b0, keep} + {53'd0, up};
  assign exp     = ExpBias + 11'd63 - {5'd0, lz} + {10'd0, rounded[53]};

  always_comb begin
    if (mag == 64'd0) dbl = 64'd0;
    else if (rounded[53]) dbl = {neg, exp, 52'd0};
    else dbl = {neg, exp, rounded[51:0]};
  end
endmodule

FILE: design/double_int64_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_int64_converter
// converts between ieee double bit patterns and signed 64-bit integers
// ----------------------------------------------------------------------------
// usage:
//   in channel carries cmd and operand; cmd 0 reads operand as a double and
//   returns the nearest integer (ties away from zero), saturating with
//   range_flag set on overflow or infinity, and 0 with the flag for nan.
//   cmd 1 reads operand as a two's complement integer and returns the
//   double rounded to nearest even; range_flag is then 0.
//   the operand is captured in an input register, converted by one pass of
//   combinational logic, and written to a result register.
//   an item reaches the output when it moves from the input register into
//   the result register. throughput: one transaction per cycle while the
//   receiver is ready, set by the single conversion pass.
//   reset clears both valid flags; no result is pending after reset.
//   when the receiver stalls the result register holds; the input register
//   keeps its item while the result register is full, so the pipe stalls
//   back to the input only when both stages are occupied.
// ----------------------------------------------------------------------------
module double_int64_converter (
  input logic clk,
  input logic rst,
  dic_in_if.sink    in_ch,
  dic_out_if.source out_ch
);
  import dic_pkg::*;

  // input stage
  logic        s1_valid;
  logic        s1_cmd;
  logic [63:0] s1_operand;
  // result stage
  logic        s2_valid;
  dic_res_t    s2_res;

  logic     s2_load;
  logic     s1_load;
  dic_res_t d2i_res;
  logic [63:0] i2d_dbl;
  dic_res_t conv_res;

  dic_d2i u_d2i (.bits(s1_operand), .res(d2i_res));
  dic_i2d u_i2d (.x(s1_operand), .dbl(i2d_dbl));

  always_comb begin
    if (cmd_t'(s1_cmd) == CMD_INT_TO_DBL) conv_res = '{result: i2d_dbl, range_flag: 1'b0};
    else conv_res = d2i_res;
  end

  // result stage free when empty or being drained
  assign s2_load     = !s2_valid || out_ch.ready;
  assign s1_load     = !s1_valid || s2_load;
  assign in_ch.ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= in_ch.valid;
      if (s2_load) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_ch.valid) begin
      s1_cmd     <= in_ch.cmd;
      s1_operand <= in_ch.operand;
    end
    if (s2_load && s1_valid) s2_res <= conv_res;
  end

  assign out_ch.valid      = s2_valid;
  assign out_ch.result     = s2_res.result;
  assign out_ch.range_flag = s2_res.range_flag;

  // stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_ch.ready |=> s2_valid && $stable(s2_res))
    else $error("result changed while stalled");
  // int to double never flags
  a_flag: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_valid && (cmd_t'(s1_cmd) == CMD_INT_TO_DBL) |=> !s2_res.range_flag)
    else $error("range flag on int to double");
  // full pipe refuses input
  a_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken with pipe full");
  // an item in stage one always moves on when stage two frees
  a_move: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_load |=> s2_valid)
    else $error("item lost between stages");
endmodule
